[rtl/core/assert_macros.svh]
// Assertion macros for the ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vrb assertion failed");
`define VRB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vrb implication failed");
`else
`define VRB_ASSERT(label, clk, rst_n, prop)
`define VRB_ASSERT_IMP(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/core/vrb_pkg.sv]
// Package with sizes, codes, types and helpers of the record ring buffer.
package vrb_pkg;
    localparam int RING_BYTES = 4096;
    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int USED_W = $clog2(RING_BYTES + 1);
    localparam int CNT_W  = $clog2(RING_BYTES / 2 + 1);
    localparam int CMD_W  = 3;
    localparam int LEN_W  = 16;
    localparam int ROOM_W = 17;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int DROP_W = 12;
    localparam int HELD_W = 12;
    localparam int SUM_W  = LEN_W + 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BEGIN = 3'd0,
        CMD_PUSH_BYTE  = 3'd1,
        CMD_POP        = 3'd2,
        CMD_PEEK_BEGIN = 3'd3,
        CMD_PEEK_BYTE  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_SMALL    = 3'd3,
        ST_SEQ      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_SEQ,
        DP_TOO_LONG,
        DP_EMPTY,
        DP_HDR_LO,
        DP_HDR_HI,
        DP_PUSH_BYTE,
        DP_RD_HEAD0,
        DP_RD_HEAD1,
        DP_EVICT,
        DP_POP,
        DP_PEEK_CHK,
        DP_RD_BYTE,
        DP_TAKE_BYTE
    } t_dp_op;

    typedef struct packed {
        logic   latch_in;
        logic   load_out;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic push_open;
        logic read_pend;
        logic empty;
        logic too_long;
        logic need_evict;
    } t_dp_status;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [LEN_W-1:0]  record_length;
        logic [ROOM_W-1:0] dest_room;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DROP_W-1:0] dropped_count;
        logic [LEN_W-1:0]  head_length;
        logic [BYTE_W-1:0] data_out;
        logic              last_byte;
        logic [HELD_W-1:0] records_held;
    } t_result;

    // ptr + inc modulo ring size; inc never exceeds the ring size
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [SUM_W-1:0] inc);
        logic [SUM_W-1:0] s;
        s = SUM_W'(ptr) + inc;
        if (s >= SUM_W'(RING_BYTES)) begin
            s = s - SUM_W'(RING_BYTES);
        end
        return s[PTR_W-1:0];
    endfunction
endpackage

[rtl/core/vrb_if.sv]
// Item channel interfaces of the record ring buffer.
interface vrb_in_if;
    import vrb_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  record_length;
    logic [ROOM_W-1:0] dest_room;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, command, record_length, dest_room, data_byte,
                    input ready);
    modport sink (input valid, command, record_length, dest_room, data_byte,
                  output ready);
endinterface

interface vrb_out_if;
    import vrb_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DROP_W-1:0] dropped_count;
    logic [LEN_W-1:0]  head_length;
    logic [BYTE_W-1:0] data_out;
    logic              last_byte;
    logic [HELD_W-1:0] records_held;
    modport source (output valid, status, dropped_count, head_length, data_out,
                    last_byte, records_held, input ready);
    modport sink (input valid, status, dropped_count, head_length, data_out,
                  last_byte, records_held, output ready);
endinterface

[rtl/core/vrb_datapath.sv]
// Datapath: byte ring memory, pointers, counters and result registers.
`include "assert_macros.svh"
module vrb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrb_pkg::t_dp_cmd    i_cmd,
    input  vrb_pkg::t_item      i_item_data,
    output vrb_pkg::t_dp_status o_status,
    output vrb_pkg::t_result    o_result
);
    import vrb_pkg::*;

    logic [BYTE_W-1:0] r_mem [RING_BYTES];
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_lo;
    t_item             r_in;
    logic [PTR_W-1:0]  r_head, r_wptr, r_rptr;
    logic [USED_W-1:0] r_used;
    logic [CNT_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_wrem, r_open, r_rrem;
    logic [STAT_W-1:0] r_res_status;
    logic [CNT_W-1:0]  r_res_dropped;
    logic [LEN_W-1:0]  r_res_hlen;
    logic [BYTE_W-1:0] r_res_dout;
    logic              r_res_last;
    t_result           r_out;

    logic [PTR_W-1:0]  tail, rd_addr, wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              wr_en;
    logic [LEN_W-1:0]  hlen;
    logic [SUM_W-1:0]  hlen_p2, len_p2, free_bytes;
    logic              too_small;

    assign tail       = wrap_add(r_head, SUM_W'(r_used));
    assign hlen       = {r_rd_data, r_lo};
    assign hlen_p2    = SUM_W'(hlen) + SUM_W'(2);
    assign len_p2     = SUM_W'(r_in.record_length) + SUM_W'(2);
    assign free_bytes = SUM_W'(RING_BYTES) - SUM_W'(r_used);
    assign too_small  = (SUM_W'(hlen) + SUM_W'(1)) > SUM_W'(r_in.dest_room);

    assign o_status.cmd        = t_cmd'(r_in.command);
    assign o_status.push_open  = r_wrem != '0;
    assign o_status.read_pend  = r_rrem != '0;
    assign o_status.empty      = r_count == '0;
    assign o_status.too_long   = len_p2 > SUM_W'(RING_BYTES);
    assign o_status.need_evict = (free_bytes < len_p2) && (r_count != '0);
    assign o_result            = r_out;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wptr;
        wr_data = r_in.data_byte;
        rd_addr = r_head;
        case (i_cmd.op)
            DP_HDR_LO: begin
                wr_en   = 1'b1;
                wr_addr = tail;
                wr_data = r_in.record_length[7:0];
            end
            DP_HDR_HI: begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(tail, SUM_W'(1));
                wr_data = r_in.record_length[15:8];
            end
            DP_PUSH_BYTE: wr_en = 1'b1;
            DP_RD_HEAD1:  rd_addr = wrap_add(r_head, SUM_W'(1));
            DP_RD_BYTE:   rd_addr = r_rptr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_used  <= '0;
            r_count <= '0;
            r_wptr  <= '0;
            r_wrem  <= '0;
            r_open  <= '0;
            r_rptr  <= '0;
            r_rrem  <= '0;
        end else begin
            case (i_cmd.op)
                DP_HDR_HI: begin
                    r_wptr <= wrap_add(tail, SUM_W'(2));
                    r_wrem <= r_in.record_length;
                    r_open <= r_in.record_length;
                    if (r_in.record_length == '0) begin
                        r_used  <= r_used + USED_W'(2);
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                DP_PUSH_BYTE: begin
                    r_wptr <= wrap_add(r_wptr, SUM_W'(1));
                    r_wrem <= r_wrem - LEN_W'(1);
                    if (r_wrem == LEN_W'(1)) begin
                        r_used  <= r_used + USED_W'(SUM_W'(r_open) + SUM_W'(2));
                        r_count <= r_count + CNT_W'(1);
                        r_open  <= '0;
                    end
                end
                DP_EVICT, DP_POP: begin
                    r_head  <= wrap_add(r_head, hlen_p2);
                    r_used  <= r_used - USED_W'(hlen_p2);
                    r_count <= r_count - CNT_W'(1);
                    r_rrem  <= '0;
                end
                DP_PEEK_CHK: begin
                    if (too_small) begin
                        r_rrem <= '0;
                    end else begin
                        r_rptr <= wrap_add(r_head, SUM_W'(2));
                        r_rrem <= hlen;
                    end
                end
                DP_TAKE_BYTE: begin
                    r_rptr <= wrap_add(r_rptr, SUM_W'(1));
                    r_rrem <= r_rrem - LEN_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in          <= i_item_data;
            r_res_status  <= ST_OK;
            r_res_dropped <= '0;
            r_res_hlen    <= '0;
            r_res_dout    <= '0;
            r_res_last    <= 1'b0;
        end
        if (i_cmd.op == DP_RD_HEAD1) begin
            r_lo <= r_rd_data;
        end
        case (i_cmd.op)
            DP_SEQ:      r_res_status <= ST_SEQ;
            DP_TOO_LONG: r_res_status <= ST_TOO_LONG;
            DP_EMPTY:    r_res_status <= ST_EMPTY;
            DP_EVICT:    r_res_dropped <= r_res_dropped + CNT_W'(1);
            DP_PEEK_CHK: begin
                r_res_hlen <= hlen;
                if (too_small) begin
                    r_res_status <= ST_SMALL;
                end
            end
            DP_TAKE_BYTE: begin
                r_res_dout <= r_rd_data;
                r_res_last <= r_rrem == LEN_W'(1);
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out.status        <= r_res_status;
            r_out.dropped_count <= DROP_W'(r_res_dropped);
            r_out.head_length   <= r_res_hlen;
            r_out.data_out      <= r_res_dout;
            r_out.last_byte     <= r_res_last;
            r_out.records_held  <= HELD_W'(r_count);
        end
    end

    `VRB_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= USED_W'(RING_BYTES))
    `VRB_ASSERT_IMP(a_empty_no_bytes, i_clk, i_rst_n, r_count == '0, r_used == '0)
    `VRB_ASSERT_IMP(a_read_needs_rec, i_clk, i_rst_n, r_rrem != '0, r_count != '0)
endmodule

[rtl/core/vrb_ctrl.sv]
// Controller: sequences each item through the datapath and owns the handshakes.
module vrb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  vrb_pkg::t_dp_status i_status,
    output vrb_pkg::t_dp_cmd    o_cmd
);
    import vrb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HDR_HI,
        S_HRD1,
        S_HDR,
        S_TAKE,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.latch_in = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.op       = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_status.cmd)
                    CMD_PUSH_BEGIN: begin
                        if (i_status.push_open) begin
                            o_cmd.op = DP_SEQ;
                        end else if (i_status.too_long) begin
                            o_cmd.op = DP_TOO_LONG;
                        end else if (i_status.need_evict) begin
                            o_cmd.op = DP_RD_HEAD0;
                            n_state  = S_HRD1;
                        end else begin
                            o_cmd.op = DP_HDR_LO;
                            n_state  = S_HDR_HI;
                        end
                    end
                    CMD_PUSH_BYTE: begin
                        o_cmd.op = i_status.push_open ? DP_PUSH_BYTE : DP_SEQ;
                    end
                    CMD_POP, CMD_PEEK_BEGIN: begin
                        if (i_status.empty) begin
                            o_cmd.op = DP_EMPTY;
                        end else begin
                            o_cmd.op = DP_RD_HEAD0;
                            n_state  = S_HRD1;
                        end
                    end
                    CMD_PEEK_BYTE: begin
                        if (i_status.read_pend) begin
                            o_cmd.op = DP_RD_BYTE;
                            n_state  = S_TAKE;
                        end else begin
                            o_cmd.op = DP_SEQ;
                        end
                    end
                    default: o_cmd.op = DP_SEQ;
                endcase
            end
            S_HDR_HI: begin
                o_cmd.op = DP_HDR_HI;
                n_state  = S_DONE;
            end
            S_HRD1: begin
                o_cmd.op = DP_RD_HEAD1;
                n_state  = S_HDR;
            end
            S_HDR: begin
                unique case (i_status.cmd)
                    CMD_PUSH_BEGIN: begin
                        o_cmd.op = DP_EVICT;
                        n_state  = S_DECODE;
                    end
                    CMD_POP: begin
                        o_cmd.op = DP_POP;
                        n_state  = S_DONE;
                    end
                    default: begin
                        o_cmd.op = DP_PEEK_CHK;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_TAKE: begin
                o_cmd.op = DP_TAKE_BYTE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

[rtl/core/variable_record_ring_buffer_core.sv]
// Top level of the length-prefixed record ring buffer.
//
//   channel    dir   carries
//   i_item     in    command, record_length, dest_room, data_byte
//   o_result   out   status, dropped_count, head_length, data_out,
//                    last_byte, records_held
//
// Steps: push_begin evicts head records while room is short, then writes the
// header bytes; pop and peek_begin read the header from the single-port byte
// ring one byte per cycle, then pop or check; peek_byte reads, then takes a byte.
// A new item is taken while the previous result still waits.
// Reset is synchronous, active low; the ring memory itself is not cleared.
module variable_record_ring_buffer_core (
    input logic      i_clk,
    input logic      i_rst_n,
    vrb_in_if.sink   i_item,
    vrb_out_if.source o_result
);
    import vrb_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_item      item_data;
    t_result    result;

    assign item_data.command       = i_item.command;
    assign item_data.record_length = i_item.record_length;
    assign item_data.dest_room     = i_item.dest_room;
    assign item_data.data_byte     = i_item.data_byte;

    assign o_result.status        = result.status;
    assign o_result.dropped_count = result.dropped_count;
    assign o_result.head_length   = result.head_length;
    assign o_result.data_out      = result.data_out;
    assign o_result.last_byte     = result.last_byte;
    assign o_result.records_held  = result.records_held;

    vrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    vrb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_item_data (item_data),
        .o_status    (dp_status),
        .o_result    (result)
    );
endmodule
